@@ hw/rtl/tsk_pkg.sv @@
// Package for the trajectory seed block: sequencer states, ring rotation constants and
// register indexes. No dependencies.
package tsk_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_VEL,
        ST_RING_MUL,
        ST_RING_ROT,
        ST_EMIT,
        ST_WAIT,
        ST_STEP,
        ST_SAT,
        ST_TEST,
        ST_SEARCH,
        ST_PICK
    } state_t;

    localparam logic [2:0] REG_MAX_SPEED = 3'd0;
    localparam logic [2:0] REG_STEP_TIME = 3'd1;
    localparam logic [2:0] REG_CENTER_X  = 3'd2;
    localparam logic [2:0] REG_CENTER_Y  = 3'd3;
    localparam logic [2:0] REG_RADIUS    = 3'd4;

    localparam logic signed [31:0] ROT_C = 32'sd1040361791;
    localparam logic signed [31:0] ROT_S = 32'sd265647978;
    localparam logic [26:0] SAFETY_Q = 27'd262144;

    // Rounded shift that takes the Q2.30 scale of one factor off a product.
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sd536870912;
        return t >>> 30;
    endfunction

endpackage

@@ hw/rtl/trajectory_seed_with_keepout.sv @@
// Top level of the trajectory seed block with circular keep-out zone.
// Depends on tsk_pkg and tsk_divider.
//
//  channel | direction | handshake        | payload
//  input   | in        | in_valid/ready   | start_x/y/z, goal_x/y/z
//  output  | out       | out_valid/ready  | point_index, pos_x/y/z, vel_x/y/z, last_point
//  config  | in        | cfg_we           | cfg_index, cfg_data
//
// After acceptance a request is normalised and squared, takes 32 square-root steps, runs three
// divisions through one shared divider and builds the ring points before its first beat.
// With start equal to goal the root and divisions are skipped.
// Each later point is stepped, saturated and tested, and searched on the ring when in the zone.
// Ready is low from acceptance until the last point has been taken.
// A stalled output holds its beat; reset returns the sequencer to idle.
module trajectory_seed_with_keepout #(
    parameter int HORIZON     = 32,
    parameter int RING_POINTS = 26
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] goal_x,
    input  logic signed [31:0] goal_y,
    input  logic signed [31:0] goal_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         point_index,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic               last_point
);
    localparam int RW = (RING_POINTS > 1) ? $clog2(RING_POINTS) : 1;

    tsk_pkg::state_t state_reg, state_next;

    logic [22:0]        max_speed_reg;
    logic [17:0]        step_time_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic [26:0]        radius_reg;

    logic signed [32:0] d_reg [3];
    logic [32:0]        mag_reg [3];
    logic signed [33:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic [1:0]         axis_reg, axis_next;
    logic [63:0]        sum_reg;
    logic [63:0]        rem_reg;
    logic [31:0]        root_reg;
    logic [4:0]         sq_cnt_reg;
    logic signed [31:0] c_reg, s_reg;
    logic signed [63:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [33:0] ring_x [RING_POINTS];
    logic signed [33:0] ring_y [RING_POINTS];
    logic [RW-1:0]      k_reg;
    logic [RW-1:0]      best_reg;
    logic [64:0]        best_d_reg;
    logic [5:0]         pt_reg;
    logic               div_start;
    logic               div_done;
    logic [54:0]        div_q;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= 23'd131072;
            step_time_reg <= 18'd13107;
            cx_reg        <= '0;
            cy_reg        <= '0;
            radius_reg    <= 27'd327680;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsk_pkg::REG_MAX_SPEED: max_speed_reg <= cfg_data[22:0];
                tsk_pkg::REG_STEP_TIME: step_time_reg <= cfg_data[17:0];
                tsk_pkg::REG_CENTER_X:  cx_reg        <= cfg_data;
                tsk_pkg::REG_CENTER_Y:  cy_reg        <= cfg_data;
                tsk_pkg::REG_RADIUS:    radius_reg    <= cfg_data[26:0];
                default: ;
            endcase
        end
    end

    // The dividend follows the axis that the division being started belongs to.
    tsk_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (55'(mag_reg[axis_next][31:0]) * 55'(max_speed_reg)),
        .divisor  ({root_reg, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    // Shared multiply input selection.
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [32:0] mmax;
    logic [64:0] trial;
    logic signed [34:0] ex, ey;
    logic signed [35:0] ax, ay;
    logic signed [63:0] step_prod;
    logic [64:0] e_sq;
    logic [64:0] r_sq;
    logic [5:0]  lz;

    always_comb
    begin
        mmax = mag_reg[0];
        if (mag_reg[1] > mmax) mmax = mag_reg[1];
        if (mag_reg[2] > mmax) mmax = mag_reg[2];
        lz = 6'd0;
        for (int b = 0; b < 33; b++)
        begin
            if (mmax[b]) lz = 6'(32 - b);
        end
    end

    assign ex = 35'(pos_reg[0]) - 35'(cx_reg);
    assign ey = 35'(pos_reg[1]) - 35'(cy_reg);
    assign ax = 36'(ring_x[k_reg]) - 36'(pos_reg[0]);
    assign ay = 36'(ring_y[k_reg]) - 36'(pos_reg[1]);
    assign r_sq = 65'(radius_reg) * 65'(radius_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            tsk_pkg::ST_SQ:
            begin
                mul_a = 34'(mag_reg[axis_reg]);
                mul_b = 34'(mag_reg[axis_reg]);
            end
            tsk_pkg::ST_STEP:
            begin
                mul_a = 34'($signed({1'b0, step_time_reg}));
                mul_b = 34'(vel_reg[axis_reg]);
            end
            tsk_pkg::ST_TEST:
            begin
                mul_a = ex[33:0];
                mul_b = ex[33:0];
            end
            tsk_pkg::ST_SEARCH:
            begin
                mul_a = ax[33:0];
                mul_b = ax[33:0];
            end
            default: ;
        endcase
    end

    assign step_prod = mul_p[63:0];
    assign e_sq = 65'(ex * ex) + 65'(ey * ey);
    // Trying root bit i costs (root + 2^i)^2 - root^2 = root * 2^(i+1) + 4^i.
    assign trial = 65'(rem_reg) - ((65'(root_reg) << (6'(sq_cnt_reg) + 6'd1))
                                   + (65'd1 << {sq_cnt_reg, 1'b0}));

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            tsk_pkg::ST_IDLE:    if (in_valid) state_next = tsk_pkg::ST_NORM;
            tsk_pkg::ST_NORM:    state_next = (mmax == 33'd0) ? tsk_pkg::ST_RING_MUL
                                                             : tsk_pkg::ST_SQ;
            tsk_pkg::ST_SQ:
            begin
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd2)
                begin
                    axis_next  = 2'd0;
                    state_next = tsk_pkg::ST_SQRT;
                end
            end
            tsk_pkg::ST_SQRT:
            begin
                if (sq_cnt_reg == 5'd0)
                begin
                    state_next = tsk_pkg::ST_DIV;
                    div_start  = 1'b1;
                end
            end
            tsk_pkg::ST_DIV:     if (div_done) state_next = tsk_pkg::ST_VEL;
            tsk_pkg::ST_VEL:
            begin
                if (axis_reg == 2'd2)
                begin
                    axis_next  = 2'd0;
                    state_next = tsk_pkg::ST_RING_MUL;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = tsk_pkg::ST_DIV;
                    div_start  = 1'b1;
                end
            end
            tsk_pkg::ST_RING_MUL: state_next = tsk_pkg::ST_RING_ROT;
            tsk_pkg::ST_RING_ROT:
                if (32'(k_reg) == RING_POINTS - 1) state_next = tsk_pkg::ST_EMIT;
                else state_next = tsk_pkg::ST_RING_MUL;
            tsk_pkg::ST_EMIT:    state_next = tsk_pkg::ST_WAIT;
            tsk_pkg::ST_WAIT:
            begin
                if (out_ready)
                begin
                    if (32'(pt_reg) == HORIZON - 1) state_next = tsk_pkg::ST_IDLE;
                    else state_next = tsk_pkg::ST_STEP;
                end
            end
            tsk_pkg::ST_STEP:
            begin
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd2)
                begin
                    axis_next  = 2'd0;
                    state_next = tsk_pkg::ST_SAT;
                end
            end
            tsk_pkg::ST_SAT:     state_next = tsk_pkg::ST_TEST;
            tsk_pkg::ST_TEST:
                state_next = (e_sq < r_sq) ? tsk_pkg::ST_SEARCH : tsk_pkg::ST_EMIT;
            tsk_pkg::ST_SEARCH:
                if (32'(k_reg) == RING_POINTS - 1) state_next = tsk_pkg::ST_PICK;
            tsk_pkg::ST_PICK:    state_next = tsk_pkg::ST_EMIT;
            default:             state_next = tsk_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsk_pkg::ST_IDLE;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tsk_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    pos_reg[0] <= 34'(start_x);
                    pos_reg[1] <= 34'(start_y);
                    pos_reg[2] <= 34'(start_z);
                    d_reg[0]   <= 33'(goal_x) - 33'(start_x);
                    d_reg[1]   <= 33'(goal_y) - 33'(start_y);
                    d_reg[2]   <= 33'(goal_z) - 33'(start_z);
                    mag_reg[0] <= (goal_x >= start_x) ? 33'(goal_x) - 33'(start_x)
                                                      : 33'(start_x) - 33'(goal_x);
                    mag_reg[1] <= (goal_y >= start_y) ? 33'(goal_y) - 33'(start_y)
                                                      : 33'(start_y) - 33'(goal_y);
                    mag_reg[2] <= (goal_z >= start_z) ? 33'(goal_z) - 33'(start_z)
                                                      : 33'(start_z) - 33'(goal_z);
                    pt_reg     <= '0;
                    k_reg      <= '0;
                    c_reg      <= 32'sd1073741824;
                    s_reg      <= '0;
                    sum_reg    <= '0;
                end
            end
            tsk_pkg::ST_NORM:
            begin
                // Bring the largest magnitude into [2^30, 2^31).
                for (int i = 0; i < 3; i++)
                begin
                    if (mmax[32]) mag_reg[i] <= mag_reg[i] >> 2;
                    else if (mmax[31]) mag_reg[i] <= mag_reg[i] >> 1;
                    else mag_reg[i] <= mag_reg[i] << (lz - 6'd2);
                end
                if (mmax == 33'd0)
                begin
                    vel_reg[0] <= '0;
                    vel_reg[1] <= '0;
                    vel_reg[2] <= '0;
                end
                sq_cnt_reg <= 5'd31;
                root_reg   <= '0;
            end
            tsk_pkg::ST_SQ:
            begin
                sum_reg <= sum_reg + mul_p[63:0];
                if (axis_reg == 2'd2) rem_reg <= sum_reg + mul_p[63:0];
            end
            tsk_pkg::ST_SQRT:
            begin
                // One result bit per cycle, most significant first.
                if (!trial[64])
                begin
                    rem_reg  <= trial[63:0];
                    root_reg <= root_reg | (32'd1 << sq_cnt_reg);
                end
                if (sq_cnt_reg != 5'd0) sq_cnt_reg <= sq_cnt_reg - 5'd1;
            end
            tsk_pkg::ST_VEL:
            begin
                vel_reg[axis_reg] <= d_reg[axis_reg][32] ? -32'(div_q) : 32'(div_q);
            end
            tsk_pkg::ST_RING_MUL:
            begin
                pa_reg <= 64'($signed({37'd0, radius_reg} + 64'(tsk_pkg::SAFETY_Q)))
                          * 64'(c_reg);
                pb_reg <= 64'($signed({37'd0, radius_reg} + 64'(tsk_pkg::SAFETY_Q)))
                          * 64'(s_reg);
                pc_reg <= 64'(c_reg) * 64'(tsk_pkg::ROT_C) - 64'(s_reg) * 64'(tsk_pkg::ROT_S);
                pd_reg <= 64'(s_reg) * 64'(tsk_pkg::ROT_C) + 64'(c_reg) * 64'(tsk_pkg::ROT_S);
            end
            tsk_pkg::ST_RING_ROT:
            begin
                // Ring points are kept unsaturated; a zone near the edge can reach past 32 bits.
                ring_x[k_reg] <= 34'(cx_reg) + 34'(tsk_pkg::rnd30(pa_reg));
                ring_y[k_reg] <= 34'(cy_reg) + 34'(tsk_pkg::rnd30(pb_reg));
                c_reg <= 32'(tsk_pkg::rnd30(pc_reg));
                s_reg <= 32'(tsk_pkg::rnd30(pd_reg));
                k_reg <= (32'(k_reg) == RING_POINTS - 1) ? '0 : k_reg + RW'(1);
            end
            tsk_pkg::ST_WAIT:
                if (out_ready) pt_reg <= pt_reg + 6'd1;
            tsk_pkg::ST_STEP:
            begin
                pos_reg[axis_reg] <= pos_reg[axis_reg]
                                     + 34'((step_prod + 64'sd32768) >>> 16);
            end
            tsk_pkg::ST_SAT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (pos_reg[i] > 34'sd2147483647) pos_reg[i] <= 34'sd2147483647;
                    else if (pos_reg[i] < -34'sd2147483648) pos_reg[i] <= -34'sd2147483648;
                end
                k_reg      <= '0;
                best_reg   <= '0;
                best_d_reg <= '1;
            end
            tsk_pkg::ST_SEARCH:
            begin
                if (65'(mul_p[65:0]) + 65'(ay * ay) < best_d_reg || k_reg == '0)
                begin
                    best_d_reg <= 65'(mul_p[65:0]) + 65'(ay * ay);
                    best_reg   <= k_reg;
                end
                k_reg <= (32'(k_reg) == RING_POINTS - 1) ? '0 : k_reg + RW'(1);
            end
            tsk_pkg::ST_PICK:
            begin
                if (ring_x[best_reg] > 34'sd2147483647) pos_reg[0] <= 34'sd2147483647;
                else if (ring_x[best_reg] < -34'sd2147483648) pos_reg[0] <= -34'sd2147483648;
                else pos_reg[0] <= ring_x[best_reg];
                if (ring_y[best_reg] > 34'sd2147483647) pos_reg[1] <= 34'sd2147483647;
                else if (ring_y[best_reg] < -34'sd2147483648) pos_reg[1] <= -34'sd2147483648;
                else pos_reg[1] <= ring_y[best_reg];
            end
            default: ;
        endcase
    end

    assign in_ready    = (state_reg == tsk_pkg::ST_IDLE);
    assign out_valid   = (state_reg == tsk_pkg::ST_WAIT);
    assign point_index = pt_reg;
    assign pos_x       = pos_reg[0][31:0];
    assign pos_y       = pos_reg[1][31:0];
    assign pos_z       = pos_reg[2][31:0];
    assign vel_x       = vel_reg[0];
    assign vel_y       = vel_reg[1];
    assign vel_z       = vel_reg[2];
    assign last_point  = (32'(pt_reg) == HORIZON - 1);
endmodule

@@ hw/rtl/tsk_divider.sv @@
// Restoring divider, one quotient bit per cycle; used for the velocity magnitudes.
// Depends on nothing outside this file.
module tsk_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [54:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [54:0] quotient
);
    logic [54:0] quo_reg;
    logic [54:0] quo_next;
    logic [33:0] rem_reg;
    logic [33:0] rem_next;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [34:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 6'd55;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, quo_reg[54]} - {2'b00, divisor};
            if (!trial[34])
            begin
                rem_next = trial[33:0];
                quo_next = {quo_reg[53:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[32:0], quo_reg[54]};
                quo_next = {quo_reg[53:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

@@ hw/rtl/tsk_checker.sv @@
// Port-level checks for the trajectory seed block, bound to the top level.
// Depends only on the top-level ports.
module tsk_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] point_index,
    input logic       last_point
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input taken while a beat is pending");
    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("beat too early");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_point) |=> in_ready)
        else $error("not idle after final beat");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(point_index))
        else $error("stalled beat changed");
endmodule

bind trajectory_seed_with_keepout tsk_checker u_tsk_checker (.*);
